// ----- rtl/core/rrwt_pkg.sv -----
// Shared constants for the round-robin wait time calculator.
package rrwt_pkg;

    localparam int MAX_PROCS   = 16;
    localparam int PROC_AW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W       = $clog2(MAX_PROCS + 1);

    localparam int BURST_W     = 16;
    localparam int QUANTUM_W   = 16;
    localparam int TIME_W      = 22;
    localparam int INDEX_W     = 6;

    localparam int IN_DATA_W   = 16;
    localparam int OUT_FIELD_W = INDEX_W + 2 * TIME_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(1);

endpackage

// ----- rtl/core/round_robin_wait_time_calculator.sv -----
// Round-robin wait time calculator: loads bursts, simulates round-robin service, reports times.

// Bursts stream in one item per cycle and are written into on-chip process
// memories; the item with tlast closes the job set (up to MAX_PROCS processes,
// extra bursts beyond that are dropped). The block then replays round-robin
// service from time zero: each pass walks the stored processes in index
// order, and every unfinished one gets min(quantum, remaining) time units.
// In every pass each process takes a memory read state, then a modify and
// write-back state; passes repeat until a pass ends with no process left
// unfinished. Results then leave in index order, each through a memory read
// state and a load of the output register that waits until the sink takes
// the previous result, the final one with tlast. The input side is held
// off (s_axis_tready low) from the closing item until the last result sits in
// the output register; the next job set may load while that result waits.
// A quantum of zero acts as one. Write the quantum only while idle.
module round_robin_wait_time_calculator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: quantum
    input  logic                             i_cfg_we,
    input  logic [rrwt_pkg::QUANTUM_W-1:0]   i_cfg_wdata,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rrwt_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [15:0] burst
    input  logic                             s_axis_tlast,   // last_in
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rrwt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // process_index, waiting,
                                                             // turnaround, zero pad
    output logic                             m_axis_tlast    // last_out
);
    import rrwt_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SIM_RD,
        S_SIM_WR,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    // process memories
    logic [BURST_W-1:0] burst_mem [MAX_PROCS];
    logic [BURST_W-1:0] rem_mem   [MAX_PROCS];
    logic [TIME_W-1:0]  comp_mem  [MAX_PROCS];

    logic [BURST_W-1:0] r_burst_rd;
    logic [BURST_W-1:0] r_rem_rd;
    logic [TIME_W-1:0]  r_comp_rd;

    // control state
    t_state              r_state,   n_state;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [PROC_AW-1:0]  r_idx,     n_idx;
    logic [TIME_W-1:0]   r_clock,   n_clock;
    logic                r_busy,    n_busy;
    logic [QUANTUM_W-1:0] r_quantum;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [INDEX_W-1:0]  r_out_index, n_out_index;
    logic [TIME_W-1:0]   r_out_wait,  n_out_wait;
    logic [TIME_W-1:0]   r_out_turn,  n_out_turn;
    logic                r_out_last,  n_out_last;

    // memory write controls
    logic                mem_we;
    logic                burst_we;
    logic                comp_we;
    logic [PROC_AW-1:0]  mem_waddr;
    logic [BURST_W-1:0]  rem_wdata;
    logic [TIME_W-1:0]   comp_wdata;

    // datapath
    logic [QUANTUM_W-1:0] slice_max;
    logic [BURST_W-1:0]   slice;
    logic [BURST_W-1:0]   rem_next;
    logic [TIME_W-1:0]    clock_next;
    logic                 idx_at_end;
    logic                 out_free;

    assign slice_max  = (r_quantum == '0) ? QUANTUM_W'(1) : r_quantum;
    assign slice      = (r_rem_rd < slice_max) ? r_rem_rd : slice_max;
    assign rem_next   = r_rem_rd - slice;
    assign clock_next = r_clock + TIME_W'(slice);
    assign idx_at_end = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign out_free   = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_turn, r_out_wait, r_out_index};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_clock     = r_clock;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_index = r_out_index;
        n_out_wait  = r_out_wait;
        n_out_turn  = r_out_turn;
        n_out_last  = r_out_last;

        mem_we      = 1'b0;
        burst_we    = 1'b0;
        comp_we     = 1'b0;
        mem_waddr   = r_idx;
        rem_wdata   = rem_next;
        comp_wdata  = clock_next;

        case (r_state)
            S_LOAD: begin
                if (s_axis_tvalid) begin
                    if (r_count < CNT_W'(MAX_PROCS)) begin
                        // remaining starts at the burst, completion at zero
                        mem_we     = 1'b1;
                        burst_we   = 1'b1;
                        comp_we    = 1'b1;
                        mem_waddr  = r_count[PROC_AW-1:0];
                        rem_wdata  = s_axis_tdata[BURST_W-1:0];
                        comp_wdata = '0;
                        n_count    = r_count + CNT_W'(1);
                    end
                    if (s_axis_tlast) begin
                        n_state = S_SIM_RD;
                        n_idx   = '0;
                        n_busy  = 1'b0;
                        n_clock = '0;
                    end
                end
            end
            S_SIM_RD: begin
                n_state = S_SIM_WR;
            end
            S_SIM_WR: begin
                if (r_rem_rd != '0) begin
                    mem_we  = 1'b1;
                    n_clock = clock_next;
                    if (rem_next == '0) begin
                        comp_we = 1'b1;
                    end else begin
                        n_busy = 1'b1;
                    end
                end
                if (idx_at_end) begin
                    n_idx = '0;
                    if (n_busy) begin
                        n_busy  = 1'b0;
                        n_state = S_SIM_RD;
                    end else begin
                        n_state = S_OUT_RD;
                    end
                end else begin
                    n_idx   = r_idx + PROC_AW'(1);
                    n_state = S_SIM_RD;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = INDEX_W'(r_idx);
                    n_out_wait  = r_comp_rd - TIME_W'(r_burst_rd);
                    n_out_turn  = r_comp_rd;
                    n_out_last  = idx_at_end;
                    if (idx_at_end) begin
                        n_state = S_LOAD;
                        n_count = '0;
                        n_clock = '0;
                        n_idx   = '0;
                    end else begin
                        n_idx   = r_idx + PROC_AW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_idx       <= '0;
            r_clock     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_quantum   <= QUANTUM_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_clock     <= n_clock;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
        end
        r_out_index <= n_out_index;
        r_out_wait  <= n_out_wait;
        r_out_turn  <= n_out_turn;
        r_out_last  <= n_out_last;
    end

    // memories: one write and one registered read a cycle, read at r_idx
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            rem_mem[mem_waddr] <= rem_wdata;
        end
        if (burst_we) begin
            burst_mem[mem_waddr] <= rem_wdata;
        end
        if (comp_we) begin
            comp_mem[mem_waddr] <= comp_wdata;
        end
        r_burst_rd <= burst_mem[r_idx];
        r_rem_rd   <= rem_mem[r_idx];
        r_comp_rd  <= comp_mem[r_idx];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PROCS))
        else $error("process count above capacity");

    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_count != '0))
        else $error("simulation or output running with no processes");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (CNT_W'(r_idx) < r_count))
        else $error("process index beyond loaded count");

    a_clock_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_clock == '0))
        else $error("schedule clock not cleared while loading");

    a_last_returns_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_LD && out_free && idx_at_end) |=> (r_state == S_LOAD))
        else $error("final result did not return to loading");
`endif

endmodule
